// ===== rtl/emc_pkg.sv =====
// Package for the energy counter power meter: field widths, status codes,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package emc_pkg;

  localparam int COUNTER_BITS  = 40;
  localparam int TIME_BITS     = 48;
  localparam int FRACTION_BITS = 16;
  localparam int INTERVAL_BITS = 32;
  localparam int WATTS_BITS    = 16;
  localparam int POWER_BITS    = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_INDEX_BITS = 2;

  // Dividend of the divider is the energy delta followed by the fraction bits.
  localparam int DIVIDEND_BITS = COUNTER_BITS + FRACTION_BITS;
  localparam int DIV_COUNT_BITS = $clog2(DIVIDEND_BITS + 1);

  localparam logic [INTERVAL_BITS-1:0] MIN_INTERVAL_RESET = INTERVAL_BITS'(100000);
  localparam logic [INTERVAL_BITS-1:0] MAX_INTERVAL_RESET = INTERVAL_BITS'(10000000);
  localparam logic [WATTS_BITS-1:0]    MAX_WATTS_RESET    = WATTS_BITS'(1000);

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_READ_FAIL    = 3'd1,
    ST_INITIAL      = 3'd2,
    ST_BAD_INTERVAL = 3'd3,
    ST_OUT_OF_RANGE = 3'd4
  } status_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MIN_INTERVAL = 2'd0,
    CFG_MAX_INTERVAL = 2'd1,
    CFG_MAX_WATTS    = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_t;

endpackage

// ===== rtl/emc_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on emc_pkg for the dividend, divisor and counter widths.
`timescale 1ns / 1ps

module emc_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [emc_pkg::DIVIDEND_BITS-1:0]   dividend,
  input  logic [emc_pkg::INTERVAL_BITS-1:0]   divisor,
  output logic                                done,
  output logic [emc_pkg::DIVIDEND_BITS-1:0]   quotient,
  output logic                                rem_nonzero
);

  logic [emc_pkg::DIV_COUNT_BITS-1:0] count;
  logic                               busy;
  logic [emc_pkg::DIVIDEND_BITS-1:0]  shreg;
  logic [emc_pkg::INTERVAL_BITS-1:0]  rem;
  logic [emc_pkg::INTERVAL_BITS-1:0]  dvs;
  logic [emc_pkg::INTERVAL_BITS:0]    trial;
  logic [emc_pkg::INTERVAL_BITS+1:0]  diff;

  // The partial remainder stays below the divisor, so the shifted value
  // needs only one bit more than the divisor.
  assign trial = {rem, shreg[emc_pkg::DIVIDEND_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= emc_pkg::DIV_COUNT_BITS'(emc_pkg::DIVIDEND_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == emc_pkg::DIV_COUNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend bits leave at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      if (!diff[emc_pkg::INTERVAL_BITS+1]) begin
        rem   <= diff[emc_pkg::INTERVAL_BITS-1:0];
        shreg <= {shreg[emc_pkg::DIVIDEND_BITS-2:0], 1'b1};
      end else begin
        rem   <= trial[emc_pkg::INTERVAL_BITS-1:0];
        shreg <= {shreg[emc_pkg::DIVIDEND_BITS-2:0], 1'b0};
      end
    end
  end

  assign quotient    = shreg;
  assign rem_nonzero = (rem != '0);

endmodule

// ===== rtl/energy_counter_power_meter.sv =====
// Top level of the energy counter power meter: sample checks, baseline
// registers, configuration registers and output register.
// Depends on emc_pkg and emc_divider.
`timescale 1ns / 1ps

// A failed read or a new baseline passes through CHECK and EMIT, a bad
// interval through CHECK, SETUP and EMIT; a sample that reaches the divider
// passes CHECK, SETUP, DIVIDE and EMIT, the bit-serial division filling DIVIDE.
// One sample is in work at a time, and EMIT waits while the output is
// stalled. Synchronous reset clears the baseline and loads the configuration
// registers with their defaults.

module energy_counter_power_meter (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // energy_count [39:0], wrap_range [79:40], timestamp_us [127:80]
  input  logic [127:0]                           s_tdata,
  // read_ok [0]
  input  logic                                   s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // power_q16 [31:0]
  output logic [emc_pkg::POWER_BITS-1:0]         m_tdata,
  // available [0], status [3:1]
  output logic [3:0]                             m_tuser,
  input  logic                                   cfg_we,
  input  logic [emc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [emc_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    SETUP,
    DIVIDE,
    EMIT
  } state_t;

  state_t state;

  logic [emc_pkg::INTERVAL_BITS-1:0] min_interval;
  logic [emc_pkg::INTERVAL_BITS-1:0] max_interval;
  logic [emc_pkg::WATTS_BITS-1:0]    max_watts;

  logic [emc_pkg::COUNTER_BITS-1:0]  last_energy;
  logic [emc_pkg::COUNTER_BITS-1:0]  last_range;
  logic [emc_pkg::TIME_BITS-1:0]     last_time;
  logic                              baseline_valid;

  logic                              in_ok;
  logic [emc_pkg::COUNTER_BITS-1:0]  in_energy;
  logic [emc_pkg::COUNTER_BITS-1:0]  in_range;
  logic [emc_pkg::TIME_BITS-1:0]     in_time;

  logic [emc_pkg::TIME_BITS-1:0]     elapsed;
  logic                              late;
  logic [emc_pkg::COUNTER_BITS-1:0]  delta;

  emc_pkg::status_t                  res_status;

  logic                              read_fail;
  logic [emc_pkg::TIME_BITS:0]       time_diff;
  logic [emc_pkg::COUNTER_BITS-1:0]  delta_next;
  logic                              interval_ok;
  logic                              div_start;
  logic                              div_done;
  logic [emc_pkg::DIVIDEND_BITS-1:0] div_quotient;
  logic                              div_rem_nonzero;
  logic [emc_pkg::COUNTER_BITS-1:0]  whole;
  logic                              over_limit;

  assign s_tready = (state == IDLE);

  assign read_fail = !in_ok || (in_range == '0) || (in_energy > in_range);
  assign time_diff = {1'b0, in_time} - {1'b0, last_time};

  // On a wrap the counter passed through the range boundary once.
  assign delta_next = (in_energy >= last_energy) ? (in_energy - last_energy)
                                                 : (in_range - last_energy + in_energy);

  assign interval_ok = !late && (elapsed != '0)
                    && (elapsed >= {{(emc_pkg::TIME_BITS-emc_pkg::INTERVAL_BITS){1'b0}},
                                    min_interval})
                    && (elapsed <= {{(emc_pkg::TIME_BITS-emc_pkg::INTERVAL_BITS){1'b0}},
                                    max_interval});

  assign div_start = (state == SETUP) && interval_ok;

  emc_divider u_divider (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend    ({delta, {emc_pkg::FRACTION_BITS{1'b0}}}),
    .divisor     (elapsed[emc_pkg::INTERVAL_BITS-1:0]),
    .done        (div_done),
    .quotient    (div_quotient),
    .rem_nonzero (div_rem_nonzero)
  );

  // Whole watts above the limit, or equal to it with anything left over.
  assign whole = div_quotient[emc_pkg::DIVIDEND_BITS-1:emc_pkg::FRACTION_BITS];
  assign over_limit =
      (whole > {{(emc_pkg::COUNTER_BITS-emc_pkg::WATTS_BITS){1'b0}}, max_watts})
   || ((whole == {{(emc_pkg::COUNTER_BITS-emc_pkg::WATTS_BITS){1'b0}}, max_watts})
       && ((div_quotient[emc_pkg::FRACTION_BITS-1:0] != '0) || div_rem_nonzero));

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= emc_pkg::MIN_INTERVAL_RESET;
      max_interval <= emc_pkg::MAX_INTERVAL_RESET;
      max_watts    <= emc_pkg::MAX_WATTS_RESET;
    end else if (cfg_we) begin
      unique case (emc_pkg::cfg_index_t'(cfg_index))
        emc_pkg::CFG_MIN_INTERVAL: min_interval <= cfg_data;
        emc_pkg::CFG_MAX_INTERVAL: max_interval <= cfg_data;
        emc_pkg::CFG_MAX_WATTS:    max_watts <= cfg_data[emc_pkg::WATTS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      baseline_valid <= 1'b0;
      last_energy    <= '0;
      last_range     <= '0;
      last_time      <= '0;
      m_tvalid       <= 1'b0;
      m_tdata        <= '0;
      m_tuser        <= '0;
      res_status     <= emc_pkg::ST_OK;
    end else begin
      // In EMIT the output register is reloaded below instead.
      if (m_tvalid && m_tready && (state != EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            in_ok     <= s_tuser;
            in_energy <= s_tdata[emc_pkg::COUNTER_BITS-1:0];
            in_range  <= s_tdata[2*emc_pkg::COUNTER_BITS-1:emc_pkg::COUNTER_BITS];
            in_time   <= s_tdata[2*emc_pkg::COUNTER_BITS+emc_pkg::TIME_BITS-1:
                                 2*emc_pkg::COUNTER_BITS];
            state     <= CHECK;
          end
        end
        CHECK: begin
          if (read_fail) begin
            baseline_valid <= 1'b0;
            last_energy    <= '0;
            last_range     <= '0;
            last_time      <= '0;
            res_status     <= emc_pkg::ST_READ_FAIL;
            state          <= EMIT;
          end else begin
            baseline_valid <= 1'b1;
            last_energy    <= in_energy;
            last_range     <= in_range;
            last_time      <= in_time;
            if (!baseline_valid || (in_range != last_range)) begin
              res_status <= emc_pkg::ST_INITIAL;
              state      <= EMIT;
            end else begin
              elapsed <= time_diff[emc_pkg::TIME_BITS-1:0];
              late    <= time_diff[emc_pkg::TIME_BITS];
              delta   <= delta_next;
              state   <= SETUP;
            end
          end
        end
        SETUP: begin
          if (interval_ok) begin
            state <= DIVIDE;
          end else begin
            res_status <= emc_pkg::ST_BAD_INTERVAL;
            state      <= EMIT;
          end
        end
        DIVIDE: begin
          if (div_done) begin
            res_status <= over_limit ? emc_pkg::ST_OUT_OF_RANGE : emc_pkg::ST_OK;
            state      <= EMIT;
          end
        end
        EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= {res_status, (res_status == emc_pkg::ST_OK)};
            m_tdata  <= (res_status == emc_pkg::ST_OK)
                        ? div_quotient[emc_pkg::POWER_BITS-1:0] : '0;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== sim/tb_energy_counter_power_meter.sv =====
// Self-checking testbench for energy_counter_power_meter: a directed table of samples,
// then random sample streams under several interval and power limit settings.
// Depends on emc_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_energy_counter_power_meter;

  localparam int CNT_W   = emc_pkg::COUNTER_BITS;
  localparam int TIME_W  = emc_pkg::TIME_BITS;
  localparam int WATTS_W = emc_pkg::WATTS_BITS;
  localparam logic [63:0] MASK40 = (64'd1 << CNT_W) - 64'd1;
  localparam int PHASE_ITEMS   = 190;
  localparam int HOLD_CYCLES   = 500;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 70;

  typedef struct packed {
    logic                     read_ok;
    logic [CNT_W-1:0]         energy_count;
    logic [CNT_W-1:0]         wrap_range;
    logic [TIME_W-1:0]        timestamp_us;
  } sample_t;

  typedef struct packed {
    logic                             available;
    logic [emc_pkg::POWER_BITS-1:0]   power_q16;
    emc_pkg::status_t                 status;
  } meter_result_t;

  typedef struct packed {
    sample_t                  smp;
    logic                     known;
    meter_result_t            want;
  } meter_row_t;

  localparam meter_result_t PREDICTED = '{1'b0, 32'd0, emc_pkg::ST_OK};
  localparam meter_result_t NO_POWER_INITIAL = '{1'b0, 32'd0, emc_pkg::ST_INITIAL};
  localparam meter_result_t NO_POWER_READ_FAIL = '{1'b0, 32'd0, emc_pkg::ST_READ_FAIL};
  localparam meter_result_t NO_POWER_BAD_INTERVAL =
      '{1'b0, 32'd0, emc_pkg::ST_BAD_INTERVAL};
  localparam meter_result_t NO_POWER_OUT_OF_RANGE =
      '{1'b0, 32'd0, emc_pkg::ST_OUT_OF_RANGE};

  logic                                   clk;
  logic                                   rst;
  logic                                   s_tvalid;
  logic                                   s_tready;
  logic [127:0]                           s_tdata;
  logic                                   s_tuser;
  logic                                   m_tvalid;
  logic                                   m_tready;
  logic [emc_pkg::POWER_BITS-1:0]         m_tdata;
  logic [3:0]                             m_tuser;
  logic                                   cfg_we;
  logic [emc_pkg::CFG_INDEX_BITS-1:0]     cfg_index;
  logic [emc_pkg::CFG_DATA_BITS-1:0]      cfg_data;

  // Predictor copy of the configuration and of the stored baseline.
  logic [emc_pkg::INTERVAL_BITS-1:0]      cfg_min;
  logic [emc_pkg::INTERVAL_BITS-1:0]      cfg_max;
  logic [WATTS_W-1:0]                     cfg_watts;
  logic [CNT_W-1:0]                       base_energy;
  logic [CNT_W-1:0]                       base_range;
  logic [TIME_W-1:0]                      base_time;
  logic                                   base_valid;

  meter_result_t                 expected_readings[$];
  meter_row_t                    directed_rows[22];
  int                            status_hits[0:4];
  int                            sent_count;
  int                            checked_count;
  int                            error_count;
  int                            burst_left;
  int                            quiet_cycles;
  int                            rx_mode;
  int                            rx_mode_left;
  int                            rx_tick;
  bit                            held_off;

  energy_counter_power_meter DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Works out the reading for one sample and moves the baseline on.
  function automatic meter_result_t predict_power(input sample_t smp);
    meter_result_t res;
    logic [63:0] elapsed;
    logic [63:0] delta;
    logic [63:0] scaled;
    res = '{1'b0, 32'd0, emc_pkg::ST_OK};
    if (!smp.read_ok || smp.wrap_range == '0 || smp.energy_count > smp.wrap_range) begin
      base_valid = 1'b0;
      base_energy = '0;
      base_range = '0;
      base_time = '0;
      res.status = emc_pkg::ST_READ_FAIL;
    end else begin
      if (!base_valid || smp.wrap_range != base_range) begin
        base_valid = 1'b1;
        res.status = emc_pkg::ST_INITIAL;
      end else begin
        elapsed = 64'(smp.timestamp_us) - 64'(base_time);
        if (smp.timestamp_us <= base_time || elapsed < 64'(cfg_min)
            || elapsed > 64'(cfg_max)) begin
          res.status = emc_pkg::ST_BAD_INTERVAL;
        end else begin
          if (smp.energy_count >= base_energy)
            delta = 64'(smp.energy_count) - 64'(base_energy);
          else
            delta = 64'(smp.wrap_range) - 64'(base_energy) + 64'(smp.energy_count);
          // Comparing against watts times interval is the exact quotient test.
          if (delta > 64'(cfg_watts) * elapsed) begin
            res.status = emc_pkg::ST_OUT_OF_RANGE;
          end else begin
            scaled = (delta << emc_pkg::FRACTION_BITS) / elapsed;
            res.available = 1'b1;
            res.power_q16 = scaled[emc_pkg::POWER_BITS-1:0];
          end
        end
      end
      base_energy = smp.energy_count;
      base_range = smp.wrap_range;
      base_time = smp.timestamp_us;
    end
    return res;
  endfunction

  // Mostly plausible continuations of the current baseline, with a share of
  // failed reads, range changes and bad intervals mixed in.
  function automatic sample_t next_sample();
    sample_t smp;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] elapsed;
    logic [63:0] cap;
    logic [63:0] delta;
    logic [63:0] energy;
    logic [63:0] rng;
    int kind;
    kind = $urandom_range(0, 15);
    lo = (cfg_min == '0) ? 64'd1 : 64'(cfg_min);
    hi = 64'(cfg_max);
    smp.read_ok = 1'b1;
    smp.energy_count = base_energy;
    smp.wrap_range = base_range;
    smp.timestamp_us = base_time;
    if (!base_valid || kind == 0) begin
      case ($urandom_range(0, 2))
        0: rng = MASK40;
        1: rng = (rand64() & MASK40) | 64'd1;
        default: rng = 64'($urandom_range(1, 2000000));
      endcase
      smp.wrap_range = rng[CNT_W-1:0];
      energy = rand64() % (rng + 64'd1);
      smp.energy_count = energy[CNT_W-1:0];
      smp.timestamp_us = TIME_W'(($urandom_range(0, 1) == 0) ? rand64() : 64'($urandom));
    end else if (kind <= 11 && lo <= hi) begin
      case ($urandom_range(0, 7))
        0: elapsed = lo;
        1: elapsed = hi;
        default: elapsed = lo + 64'($urandom_range(0, 32'(hi - lo)));
      endcase
      cap = 64'(cfg_watts) * elapsed;
      case ($urandom_range(0, 7))
        0: delta = cap;
        1: delta = cap + 64'd1;
        default: delta = rand64() % (cap + 64'd1);
      endcase
      if (delta > 64'(base_range))
        delta = rand64() % (64'(base_range) + 64'd1);
      energy = 64'(base_energy) + delta;
      if (energy > 64'(base_range))
        energy = energy - 64'(base_range);
      smp.energy_count = energy[CNT_W-1:0];
      smp.timestamp_us = TIME_W'(64'(base_time) + elapsed);
    end else begin
      energy = rand64() % (64'(base_range) + 64'd1);
      case ($urandom_range(0, 5))
        0: begin
          smp = {65'd0, rand64()};
          smp.read_ok = 1'b0;
          smp.wrap_range = CNT_W'(rand64());
        end
        1: begin
          smp.wrap_range = '0;
          smp.energy_count = CNT_W'(rand64());
          smp.timestamp_us = TIME_W'(rand64());
        end
        2: begin
          rng = rand64() % MASK40;
          smp.wrap_range = rng[CNT_W-1:0];
          smp.energy_count = CNT_W'(rng + 64'd1 + rand64() % (MASK40 - rng));
        end
        3: begin
          smp.energy_count = energy[CNT_W-1:0];
          if ($urandom_range(0, 1) == 0)
            smp.timestamp_us =
                TIME_W'(64'(base_time) - rand64() % (64'(base_time) + 64'd1));
        end
        4: begin
          if ($urandom_range(0, 1) == 0 && lo > 64'd1)
            elapsed = 64'($urandom_range(1, 32'(lo - 64'd1)));
          else
            elapsed = hi + 64'd1 + 64'($urandom_range(0, 1000));
          smp.energy_count = energy[CNT_W-1:0];
          smp.timestamp_us = TIME_W'(64'(base_time) + elapsed);
        end
        default: begin
          smp.read_ok = 1'($urandom_range(0, 1));
          smp.energy_count = CNT_W'(rand64());
          smp.wrap_range = CNT_W'(rand64());
          smp.timestamp_us = TIME_W'(rand64());
        end
      endcase
    end
    return smp;
  endfunction

  // Offers one sample in bursts with random gaps; the reading is predicted
  // at the edge where the input transaction completes.
  task automatic send_sample(input sample_t smp, input bit known, input meter_result_t want);
    meter_result_t res;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {smp.timestamp_us, smp.wrap_range, smp.energy_count};
    s_tuser <= smp.read_ok;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = predict_power(smp);
    expected_readings.insert(expected_readings.size(), known ? want : res);
    status_hits[res.status]++;
    sent_count++;
  endtask

  task automatic wait_until_idle(input int settle);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input emc_pkg::cfg_index_t idx,
                           input logic [emc_pkg::CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      emc_pkg::CFG_MIN_INTERVAL: cfg_min = value;
      emc_pkg::CFG_MAX_INTERVAL: cfg_max = value;
      emc_pkg::CFG_MAX_WATTS:    cfg_watts = value[WATTS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
    error_count++;
    if (error_count <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want_v, got_v);
  endtask

  // Output side: compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    meter_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      checked_count++;
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected result", 64'd0, 64'({m_tuser, m_tdata}));
      end else begin
        want = expected_readings.pop_front();
        if (m_tuser[0] !== want.available)
          report_mismatch("available", 64'(want.available), 64'(m_tuser[0]));
        if (m_tdata !== want.power_q16)
          report_mismatch("power_q16", 64'(want.power_q16), 64'(m_tdata));
        if (m_tuser[3:1] !== want.status)
          report_mismatch("status", 64'(want.status), 64'(m_tuser[3:1]));
      end
    end
  end

  // Receiver stalls on patterns of its own, plus one long hold-off that
  // backs the block up and stalls its input.
  initial begin
    m_tready = 1'b0;
    rx_mode_left = 0;
    rx_tick = 0;
    held_off = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && checked_count >= 300) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_tick % 5) < 2;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("energy_counter_power_meter test failed");
        $finish;
      end
    end
  end

  initial begin
    logic [emc_pkg::INTERVAL_BITS-1:0] ph_min[5];
    logic [emc_pkg::INTERVAL_BITS-1:0] ph_max[5];
    logic [WATTS_W-1:0]                ph_watts[5];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = emc_pkg::CFG_MIN_INTERVAL;
    cfg_data = '0;
    quiet_cycles = 0;
    sent_count = 0;
    checked_count = 0;
    error_count = 0;
    burst_left = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    cfg_min = emc_pkg::MIN_INTERVAL_RESET;
    cfg_max = emc_pkg::MAX_INTERVAL_RESET;
    cfg_watts = emc_pkg::MAX_WATTS_RESET;
    base_energy = '0;
    base_range = '0;
    base_time = '0;
    base_valid = 1'b0;

    // Rows run under the reset limits: 100 ms to 10 s, 1000 W.
    directed_rows = '{
      '{'{1'b1, 40'd5, 40'd100, 48'd1000}, 1'b1, NO_POWER_INITIAL},
      '{'{1'b0, 40'd5, 40'd100, 48'd2000}, 1'b1, NO_POWER_READ_FAIL},
      '{'{1'b1, 40'd0, 40'd0, 48'd0}, 1'b1, NO_POWER_READ_FAIL},
      '{'{1'b1, 40'd101, 40'd100, 48'd0}, 1'b1, NO_POWER_READ_FAIL},
      '{'{1'b1, 40'd0, 40'd1000000, 48'd0}, 1'b1, NO_POWER_INITIAL},
      '{'{1'b1, 40'd100000, 40'd1000000, 48'd100000}, 1'b1,
        '{1'b1, 32'h0001_0000, emc_pkg::ST_OK}},
      '{'{1'b1, 40'd150000, 40'd1000000, 48'd199999}, 1'b1, NO_POWER_BAD_INTERVAL},
      '{'{1'b1, 40'd150000, 40'd1000000, 48'd5}, 1'b1, NO_POWER_BAD_INTERVAL},
      '{'{1'b1, 40'd150000, 40'd1000000, 48'd5}, 1'b1, NO_POWER_BAD_INTERVAL},
      '{'{1'b1, 40'd200000, 40'd1000000, 48'd10000005}, 1'b0, PREDICTED},
      '{'{1'b1, 40'd200000, 40'd1000000, 48'd20000006}, 1'b1, NO_POWER_BAD_INTERVAL},
      // Counter wrapped past its range.
      '{'{1'b1, 40'd100, 40'd1000000, 48'd20100006}, 1'b0, PREDICTED},
      '{'{1'b1, 40'd100, 40'd1000000000, 48'd30000000}, 1'b1, NO_POWER_INITIAL},
      '{'{1'b1, 40'd100000101, 40'd1000000000, 48'd30100000}, 1'b1, NO_POWER_OUT_OF_RANGE},
      '{'{1'b1, 40'd200000101, 40'd1000000000, 48'd30200000}, 1'b1,
        '{1'b1, 32'h03E8_0000, emc_pkg::ST_OK}},
      '{'{1'b1, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF}, 1'b1, NO_POWER_INITIAL},
      '{'{1'b1, 40'd0, 40'hFF_FFFF_FFFF, 48'd0}, 1'b1, NO_POWER_BAD_INTERVAL},
      '{'{1'b1, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 48'd100000}, 1'b1, NO_POWER_OUT_OF_RANGE},
      '{'{1'b0, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF}, 1'b1,
        NO_POWER_READ_FAIL},
      '{'{1'b1, 40'd0, 40'd1, 48'd0}, 1'b1, NO_POWER_INITIAL},
      '{'{1'b1, 40'd1, 40'd1, 48'd100000}, 1'b1, '{1'b1, 32'd0, emc_pkg::ST_OK}},
      '{'{1'b1, 40'd0, 40'd1, 48'd200000}, 1'b1, '{1'b1, 32'd0, emc_pkg::ST_OK}}
    };

    ph_min[0] = '0;            ph_max[0] = '1;            ph_watts[0] = '1;
    ph_min[1] = 32'd1;         ph_max[1] = 32'd1000;      ph_watts[1] = '0;
    ph_min[2] = emc_pkg::MIN_INTERVAL_RESET;
    ph_max[2] = emc_pkg::MAX_INTERVAL_RESET;
    ph_watts[2] = emc_pkg::MAX_WATTS_RESET;
    ph_min[3] = $urandom_range(1, 5000);
    ph_max[3] = ph_min[3] + $urandom_range(0, 200000);
    ph_watts[3] = WATTS_W'($urandom_range(1, 65535));
    ph_min[4] = '1;            ph_max[4] = '1;
    ph_watts[4] = WATTS_W'($urandom_range(0, 65535));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_sample(directed_rows[i].smp, directed_rows[i].known, directed_rows[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      wait_until_idle(4);
      write_reg(emc_pkg::CFG_MIN_INTERVAL, ph_min[ph]);
      write_reg(emc_pkg::CFG_MAX_INTERVAL, ph_max[ph]);
      write_reg(emc_pkg::CFG_MAX_WATTS, 32'(ph_watts[ph]));
      // The spare index must leave every register untouched.
      if (ph == 0)
        write_reg(emc_pkg::CFG_UNUSED, $urandom);
      repeat (PHASE_ITEMS) send_sample(next_sample(), 1'b0, PREDICTED);
    end

    wait_until_idle(SETTLE_CYCLES);
    $display("Sent %0d samples and checked %0d readings under 6 limit settings.",
             sent_count, checked_count);
    $display("Readings: ok %0d, read failed %0d, initial %0d, bad interval %0d, over limit %0d.",
             status_hits[emc_pkg::ST_OK], status_hits[emc_pkg::ST_READ_FAIL],
             status_hits[emc_pkg::ST_INITIAL], status_hits[emc_pkg::ST_BAD_INTERVAL],
             status_hits[emc_pkg::ST_OUT_OF_RANGE]);
    if (error_count == 0 && expected_readings.size() == 0) begin
      $display("energy_counter_power_meter test passed");
    end else begin
      $display("%0d mismatches, %0d readings outstanding", error_count,
               expected_readings.size());
      $display("energy_counter_power_meter test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/emc_pkg.sv
rtl/emc_divider.sv
rtl/energy_counter_power_meter.sv
sim/tb_energy_counter_power_meter.sv
